// ===== hdl/pes_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic event scheduler package
// Shared widths, operation codes, controller states and the command and
// status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package pes_pkg;

  // Field widths of the stream beats.
  localparam int IDX_W       = 3;
  localparam int TIME_W      = 64;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_PAD_W   = OUT_TDATA_W - IDX_W - TIME_W;

  // Bit positions inside the input tdata.
  localparam int IN_IDX_LSB    = 0;
  localparam int IN_PERIOD_LSB = IDX_W;
  localparam int IN_NOW_LSB    = IDX_W + TIME_W;

  // Alarm value when no event is enabled.
  localparam logic [TIME_W-1:0] ALL_ONES = '1;

  // Operation carried in the input tuser.
  typedef enum logic {
    OP_REGISTER = 1'b0,
    OP_SERVICE  = 1'b1
  } op_t;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE       = 5'b00001,
    S_REG_SUM    = 5'b00010,
    S_REG_COMMIT = 5'b00100,
    S_SCAN       = 5'b01000,
    S_FINISH     = 5'b10000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture the input beat, start a run
    logic reg_sum;      // compute the due time of a register operation
    logic reg_commit;   // write the table and alarm, emit the report beat
    logic scan_step;    // process the current table entry
    logic scan_finish;  // program the alarm, emit the final beat
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_service;   // the offered input beat is a service operation
    logic out_free;     // the output register can take a beat this cycle
    logic fire_now;     // the current table entry is due
    logic scan_last;    // the current table entry is the last one
  } sts_t;

endpackage

// ===== hdl/pes_ctrl.sv =====
// ----------------------------------------------------------------------------
// Periodic event scheduler controller
// Sequences register and service operations and issues datapath commands.
// ----------------------------------------------------------------------------
module pes_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output pes_pkg::cmd_t  cmd,
  input  pes_pkg::sts_t  sts
);

  pes_pkg::state_t state_r;
  pes_pkg::state_t state_nxt;

  // Next state and command decode.
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    state_nxt = state_r;
    case (state_r)
      pes_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.op_service ? pes_pkg::S_SCAN : pes_pkg::S_REG_SUM;
        end
      end
      pes_pkg::S_REG_SUM: begin
        cmd.reg_sum = 1'b1;
        state_nxt   = pes_pkg::S_REG_COMMIT;
      end
      pes_pkg::S_REG_COMMIT: begin
        if (sts.out_free) begin
          cmd.reg_commit = 1'b1;
          state_nxt      = pes_pkg::S_IDLE;
        end
      end
      pes_pkg::S_SCAN: begin
        // A due entry needs room in the output register before it can move on.
        if (!sts.fire_now || sts.out_free) begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) begin
            state_nxt = pes_pkg::S_FINISH;
          end
        end
      end
      pes_pkg::S_FINISH: begin
        if (sts.out_free) begin
          cmd.scan_finish = 1'b1;
          state_nxt       = pes_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pes_pkg::S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pes_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/pes_dp.sv =====
// ----------------------------------------------------------------------------
// Periodic event scheduler datapath
// Event tables, alarm register, scan pipeline and the output register.
// ----------------------------------------------------------------------------
module pes_dp #(
  parameter int MAX_EVENTS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [pes_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tuser,
  input  pes_pkg::cmd_t                      cmd,
  output pes_pkg::sts_t                      sts,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pes_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tuser,
  output logic                               out_tlast
);

  localparam int SW    = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int CMP_W = 6;

  // Captured input beat.
  logic [pes_pkg::IDX_W-1:0]  idx_r;
  logic [pes_pkg::TIME_W-1:0] period_r;
  logic [pes_pkg::TIME_W-1:0] now_r;
  logic [pes_pkg::TIME_W-1:0] due_r;

  // Event state.
  logic [MAX_EVENTS-1:0]      enabled_r;
  logic [pes_pkg::TIME_W-1:0] per_r [MAX_EVENTS];
  logic [pes_pkg::TIME_W-1:0] nd_r  [MAX_EVENTS];
  logic [pes_pkg::TIME_W-1:0] alarm_r;

  // Scan pipeline.
  logic [SW-1:0]              scan_idx_r;
  logic [pes_pkg::TIME_W-1:0] cand_r;
  logic                       cand_valid_r;
  logic [pes_pkg::TIME_W-1:0] min_r;
  logic [pes_pkg::TIME_W-1:0] min_nxt;

  // Output register.
  logic                       out_valid_r;
  logic                       out_fired_r;
  logic [pes_pkg::IDX_W-1:0]  out_idx_r;
  logic [pes_pkg::TIME_W-1:0] out_alarm_r;
  logic                       out_last_r;

  logic                       idx_ok;
  logic [SW-1:0]              reg_slot;
  logic [pes_pkg::TIME_W-1:0] alarm_reg_new;
  logic                       en_cur;
  logic [pes_pkg::TIME_W-1:0] nd_cur;
  logic [pes_pkg::TIME_W-1:0] per_cur;
  logic                       fire_now;
  logic [pes_pkg::TIME_W-1:0] sum_scan;
  logic                       scan_last;
  logic                       out_free;

  // Register operation decode and alarm update.
  assign idx_ok        = (CMP_W'(idx_r) < CMP_W'(MAX_EVENTS));
  assign reg_slot      = SW'(idx_r);
  assign alarm_reg_new = ((alarm_r > due_r) || (alarm_r <= now_r)) ? due_r : alarm_r;

  // Current scan entry: due test and reschedule sum in parallel.
  assign en_cur    = enabled_r[scan_idx_r];
  assign nd_cur    = nd_r[scan_idx_r];
  assign per_cur   = per_r[scan_idx_r];
  assign fire_now  = en_cur && (nd_cur <= now_r);
  assign sum_scan  = now_r + per_cur;
  assign scan_last = (scan_idx_r == SW'(MAX_EVENTS - 1));

  // Running minimum takes the previous entry's next due time.
  assign min_nxt = (cand_valid_r && (cand_r < min_r)) ? cand_r : min_r;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    sts            = '0;
    sts.op_service = (in_tuser == pes_pkg::OP_SERVICE);
    sts.out_free   = out_free;
    sts.fire_now   = fire_now;
    sts.scan_last  = scan_last;
  end

  // Input capture and register operation due time.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r    <= in_tdata[pes_pkg::IN_IDX_LSB +: pes_pkg::IDX_W];
      period_r <= in_tdata[pes_pkg::IN_PERIOD_LSB +: pes_pkg::TIME_W];
      now_r    <= in_tdata[pes_pkg::IN_NOW_LSB +: pes_pkg::TIME_W];
    end
    if (cmd.reg_sum) begin
      due_r <= now_r + period_r;
    end
  end

  // Period and next due tables.
  always_ff @(posedge clk) begin
    if (cmd.reg_commit && idx_ok) begin
      per_r[reg_slot] <= period_r;
      nd_r[reg_slot]  <= due_r;
    end else if (cmd.scan_step && fire_now) begin
      nd_r[scan_idx_r] <= sum_scan;
    end
  end

  // Enable flags, alarm and scan control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r    <= '0;
      alarm_r      <= '0;
      scan_idx_r   <= '0;
      cand_valid_r <= 1'b0;
    end else begin
      if (cmd.reg_commit && idx_ok) begin
        enabled_r[reg_slot] <= 1'b1;
        alarm_r             <= alarm_reg_new;
      end else if (cmd.scan_finish) begin
        alarm_r <= min_nxt;
      end
      if (cmd.load) begin
        scan_idx_r <= '0;
      end else if (cmd.scan_step && !scan_last) begin
        scan_idx_r <= scan_idx_r + SW'(1);
      end
      cand_valid_r <= cmd.scan_step && en_cur;
    end
  end

  // Candidate and running minimum.
  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      cand_r <= fire_now ? sum_scan : nd_cur;
    end
    if (cmd.load) begin
      min_r <= pes_pkg::ALL_ONES;
    end else begin
      min_r <= min_nxt;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.reg_commit || cmd.scan_finish || (cmd.scan_step && fire_now)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.reg_commit) begin
      out_fired_r <= idx_ok;
      out_idx_r   <= idx_ok ? idx_r : '0;
      out_alarm_r <= idx_ok ? alarm_reg_new : alarm_r;
      out_last_r  <= 1'b1;
    end else if (cmd.scan_step && fire_now) begin
      out_fired_r <= 1'b1;
      out_idx_r   <= pes_pkg::IDX_W'(scan_idx_r);
      out_alarm_r <= '0;
      out_last_r  <= 1'b0;
    end else if (cmd.scan_finish) begin
      out_fired_r <= 1'b0;
      out_idx_r   <= '0;
      out_alarm_r <= min_nxt;
      out_last_r  <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{pes_pkg::OUT_PAD_W{1'b0}}, out_alarm_r, out_idx_r};
  assign out_tuser  = out_fired_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== hdl/periodic_event_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// Periodic event scheduler
// A table of periodic events that share one alarm compare value.
//
//   Channel  | Direction | Payload
//   ---------+-----------+----------------------------------------------------
//   in_      | slave     | tuser: operation; tdata: index, period, now
//   out_     | master    | tuser: fired; tdata: fired index, alarm; tlast
//
// A register operation goes from its input beat through the sum and commit
// states to its result in the output register. A service operation scans
// one table entry per cycle through a single add and compare unit, and the
// finish state then programs the alarm. A stalled output holds the scan at
// the next due entry. One item is in flight at a time. Reset is synchronous
// and clears the enable flags and the alarm.
// ----------------------------------------------------------------------------
module periodic_event_scheduler_unit #(
  parameter int MAX_EVENTS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [2:0] event_index, [66:3] period, [130:67] now, rest zero
  input  logic [pes_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] operation
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [2:0] fired_index, [66:3] alarm compare, rest zero
  output logic [pes_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [0] fired
  output logic                             out_tuser,
  output logic                             out_tlast
);

  pes_pkg::cmd_t cmd;
  pes_pkg::sts_t sts;

  // Controller.
  pes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath.
  pes_dp #(
    .MAX_EVENTS (MAX_EVENTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hdl/pes_checker.sv =====
// ----------------------------------------------------------------------------
// Periodic event scheduler checker
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pes_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [pes_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [pes_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                             out_tuser,
  input logic                             out_tlast
);

  // A stalled output beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // Beats before the last one of a run are event notifications with no alarm.
  a_mid_fired: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser && (out_tdata[66:3] == 64'd0))
    else $error("non-final beat is not a plain notification");

  // A final beat without a notification carries a zero index.
  a_final_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && !out_tuser |-> (out_tdata[2:0] == 3'd0))
    else $error("final beat has a stray index");

  // One item at a time: the input closes right after it takes a beat.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted a second beat during a run");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind periodic_event_scheduler_unit pes_checker u_pes_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== bench/periodic_event_scheduler_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic event scheduler testbench
// Drives register and service beats into the scheduler and predicts every
// result beat from its own copy of the event table and alarm. The scoreboard
// compares each beat field by field, in order. It runs directed corner cases
// first, then a long random tick sequence under changing back-pressure.
// ----------------------------------------------------------------------------
module periodic_event_scheduler_unit_tb;

  localparam int MAX_EVENTS     = 8;
  localparam int RANDOM_ITEMS   = 435;
  localparam int PHASE_ITEMS    = 150;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IN_PAD_W       = pes_pkg::IN_TDATA_W - pes_pkg::IDX_W - 2 * pes_pkg::TIME_W;

  typedef logic [pes_pkg::TIME_W-1:0] tick_t;
  typedef logic [pes_pkg::IDX_W-1:0]  slot_t;

  // One result beat as the scheduler should send it.
  typedef struct packed {
    logic  fired;
    slot_t idx;
    tick_t alarm;
    logic  last;
  } sched_beat_t;

  // Event table mirror and the queue of beats it predicts.
  class sched_scoreboard;
    bit          slot_on     [MAX_EVENTS];
    tick_t       slot_period [MAX_EVENTS];
    tick_t       slot_due    [MAX_EVENTS];
    tick_t       alarm_cmp;
    sched_beat_t pending_beats[$];
    int          failures;
    int          beats_checked;
    int          register_ops;
    int          service_ops;
    int          notifications;
    int          wrapped_dues;

    function new();
      foreach (slot_on[i]) slot_on[i] = 1'b0;
      alarm_cmp = '0;
    endfunction

    // Update the table for one accepted input beat and queue its results.
    function void note_request(pes_pkg::op_t op, slot_t idx, tick_t period, tick_t now);
      sched_beat_t beat;
      tick_t       due;
      tick_t       earliest;
      if (op == pes_pkg::OP_REGISTER) begin
        register_ops++;
        if (int'(idx) >= MAX_EVENTS) begin
          beat = '{fired: 1'b0, idx: '0, alarm: alarm_cmp, last: 1'b1};
        end else begin
          due = now + period;
          if (due < now) wrapped_dues++;
          slot_period[idx] = period;
          slot_due[idx]    = due;
          slot_on[idx]     = 1'b1;
          // Pull the alarm in when it is later than the new due time or stale.
          if (alarm_cmp > due || alarm_cmp <= now) alarm_cmp = due;
          beat = '{fired: 1'b1, idx: idx, alarm: alarm_cmp, last: 1'b1};
        end
        pending_beats.push_back(beat);
      end else begin
        service_ops++;
        earliest = pes_pkg::ALL_ONES;
        for (int i = 0; i < MAX_EVENTS; i++) begin
          if (slot_on[i]) begin
            if (slot_due[i] <= now) begin
              beat = '{fired: 1'b1, idx: slot_t'(i), alarm: '0, last: 1'b0};
              pending_beats.push_back(beat);
              notifications++;
              slot_due[i] = now + slot_period[i];
              if (slot_due[i] < now) wrapped_dues++;
            end
            if (slot_due[i] < earliest) earliest = slot_due[i];
          end
        end
        alarm_cmp = earliest;
        beat = '{fired: 1'b0, idx: '0, alarm: alarm_cmp, last: 1'b1};
        pending_beats.push_back(beat);
      end
    endfunction

    function void report(string field, tick_t exp_val, tick_t act_val);
      failures++;
      if (failures <= 40)
        $display("%0t: mismatch in %s: expected 0x%0h, actual 0x%0h",
                 $time, field, exp_val, act_val);
    endfunction

    // Compare one accepted result beat with the oldest expectation.
    function void check_beat(logic fired, slot_t idx, tick_t alarm, logic last,
                             logic [pes_pkg::OUT_PAD_W-1:0] pad);
      sched_beat_t want;
      beats_checked++;
      if (pending_beats.size() == 0) begin
        failures++;
        if (failures <= 40)
          $display("%0t: unexpected beat: fired %0b index %0d alarm 0x%0h last %0b",
                   $time, fired, idx, alarm, last);
        return;
      end
      want = pending_beats.pop_front();
      if (fired !== want.fired) report("fired", tick_t'(want.fired), tick_t'(fired));
      if (idx !== want.idx) report("fired_index", tick_t'(want.idx), tick_t'(idx));
      if (alarm !== want.alarm) report("alarm compare", want.alarm, alarm);
      if (last !== want.last) report("last", tick_t'(want.last), tick_t'(last));
      if (pad !== '0) report("tdata padding", '0, tick_t'(pad));
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [pes_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                            in_tuser   = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [pes_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tuser;
  logic                            out_tlast;

  sched_scoreboard sb = new();

  // Traffic shape shared by the sender and the receiver.
  int unsigned send_idle_pct[3] = '{35, 55, 0};
  int unsigned recv_idle_pct[3] = '{55, 35, 0};
  int          traffic_phase    = 0;
  bit          hold_request     = 1'b0;
  tick_t       tick_base        = '0;

  periodic_event_scheduler_unit #(
    .MAX_EVENTS(MAX_EVENTS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic tick_t rand_tick();
    return {$urandom, $urandom};
  endfunction

  // Offer one input beat after a random gap and wait until it is taken.
  task automatic send_beat(pes_pkg::op_t op, slot_t idx, tick_t period, tick_t now);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct[traffic_phase]) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{IN_PAD_W{1'b0}}, now, period, idx};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, idx, period, now);
  endtask

  // Corner cases: empty table, zero and all-ones fields, wrapping due times.
  task automatic run_directed();
    send_beat(pes_pkg::OP_SERVICE, 3'd0, '0, '0);
    send_beat(pes_pkg::OP_REGISTER, 3'd0, '0, '0);
    send_beat(pes_pkg::OP_SERVICE, 3'd0, pes_pkg::ALL_ONES, '0);
    send_beat(pes_pkg::OP_REGISTER, 3'd7, pes_pkg::ALL_ONES, pes_pkg::ALL_ONES);
    send_beat(pes_pkg::OP_REGISTER, 3'd1, 64'd1, pes_pkg::ALL_ONES);
    for (int i = 2; i < 7; i++)
      send_beat(pes_pkg::OP_REGISTER, slot_t'(i), tick_t'(5 * i), 64'd100);
    send_beat(pes_pkg::OP_SERVICE, 3'd5, 64'd3, 64'd120);
    send_beat(pes_pkg::OP_SERVICE, 3'd0, '0, pes_pkg::ALL_ONES);
    send_beat(pes_pkg::OP_SERVICE, 3'd7, pes_pkg::ALL_ONES, '0);
    send_beat(pes_pkg::OP_REGISTER, 3'd3, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFF0);
    send_beat(pes_pkg::OP_REGISTER, 3'd0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_beat(pes_pkg::OP_REGISTER, 3'd4, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_beat(pes_pkg::OP_SERVICE, 3'd2, '0, 64'hFFFF_FFFF_FFFF_FFF8);
    send_beat(pes_pkg::OP_SERVICE, 3'd6, '0, 64'h0000_0000_0000_0010);
    send_beat(pes_pkg::OP_REGISTER, 3'd5, '0, 64'd200);
  endtask

  // Random traffic: mostly a forward-running tick with short periods so
  // events keep firing, plus jumps, near-wrap ticks and stray time values.
  task automatic run_random(int count);
    pes_pkg::op_t op;
    slot_t        idx;
    tick_t        period;
    tick_t        now;
    int           pick;
    for (int n = 0; n < count; n++) begin
      traffic_phase = n / PHASE_ITEMS;
      if (traffic_phase > 2) traffic_phase = 2;
      if (n == 2 * PHASE_ITEMS) hold_request = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 4) tick_base = rand_tick();
      else if (pick < 7) tick_base = pes_pkg::ALL_ONES - tick_t'($urandom_range(0, 300));
      else tick_base = tick_base + tick_t'($urandom_range(0, 40));
      op  = ($urandom_range(0, 99) < 35) ? pes_pkg::OP_REGISTER : pes_pkg::OP_SERVICE;
      idx = slot_t'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 85) period = tick_t'($urandom_range(1, 120));
      else if (pick < 93) period = rand_tick();
      else if (pick < 97) period = pes_pkg::ALL_ONES - tick_t'($urandom_range(0, 50));
      else period = '0;
      now = ($urandom_range(0, 99) < 5) ? rand_tick() : tick_base;
      send_beat(op, idx, period, now);
    end
  endtask

  // Result side: check accepted beats, then choose tready for the next cycle.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        sb.check_beat(out_tuser, out_tdata[pes_pkg::IDX_W-1:0],
                      out_tdata[pes_pkg::IDX_W +: pes_pkg::TIME_W], out_tlast,
                      out_tdata[pes_pkg::OUT_TDATA_W-1:pes_pkg::IDX_W+pes_pkg::TIME_W]);
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct[traffic_phase]);
      end
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Main sequence: reset, directed cases, random traffic, drain.
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random(RANDOM_ITEMS);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d register and %0d service operations, %0d notifications,",
             sb.register_ops, sb.service_ops, sb.notifications);
    $display("%0d wrapped due times and %0d result beats under varying back-pressure.",
             sb.wrapped_dues, sb.beats_checked);
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
